FILE: rtl/vsid_pkg.sv
// Package for the voltage sag and interruption detector.
// Field widths, register indexes, threshold reset values and the detector result type.
// No dependencies.
package vsid_pkg;

	localparam int LEVEL_W = 16;
	localparam int TIME_W  = 32;
	localparam int TICK_W  = 32;
	localparam int CFG_W   = 16;

	localparam int IN_DATA_W  = 48;
	localparam int OUT_DATA_W = 136;

	localparam logic [LEVEL_W-1:0] SAG_THR_RESET = 16'd17600;
	localparam logic [LEVEL_W-1:0] INT_THR_RESET = 16'd220;

	typedef enum logic [0:0] {
		REG_SAG_THR = 1'b0,
		REG_INT_THR = 1'b1
	} cfg_reg_t;

	// What one detector reports for one beat.
	typedef struct packed {
		logic              active;
		logic              done;
		logic [TICK_W-1:0] ticks;
		logic [TIME_W-1:0] begin_time;
	} det_res_t;

endpackage

FILE: rtl/vsid_det.sv
// One event detector: active flag, onset time and saturating tick count.
// Depends on vsid_pkg.
module vsid_det
	import vsid_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              step,
	input  logic              cond,
	input  logic [TIME_W-1:0] now,
	output det_res_t          res
);

	logic              flag_q;
	logic [TICK_W-1:0] count_q;
	logic [TIME_W-1:0] begin_q;

	logic              onset;
	logic              ending;
	logic              flag_d;
	logic [TICK_W-1:0] count_d;

	always_comb begin
		onset  = cond && !flag_q;
		ending = !cond && flag_q;
		flag_d = cond;
		// The count is already zero at onset, since an end or reset cleared it.
		if (!flag_d) begin
			count_d = '0;
		end else if (&count_q) begin
			count_d = count_q;
		end else begin
			count_d = count_q + TICK_W'(1);
		end
		res.active     = flag_d;
		res.done       = ending;
		res.ticks      = ending ? count_q : '0;
		res.begin_time = ending ? begin_q : '0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			flag_q  <= 1'b0;
			count_q <= '0;
			begin_q <= '0;
		end else if (step) begin
			flag_q  <= flag_d;
			count_q <= count_d;
			if (onset) begin
				begin_q <= now;
			end
		end
	end

endmodule

FILE: rtl/voltage_sag_interruption_detector.sv
// Top level of the voltage sag and interruption detector.
// Depends on vsid_pkg and vsid_det.
//
// Each input beat carries one half-period level and the current time; each one yields
// exactly one output beat with both detectors' states and, on an event end, its duration
// and start time. A beat passes an input register and a result register before its result is
// presented. While the output is not stalled a new beat is taken every clock: the detector
// state updates as a beat leaves the input register. The user must write thresholds through
// the cfg port only while no beat is in flight; the block itself does not enforce this.
module voltage_sag_interruption_detector
	import vsid_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_tvalid,
	output logic                  s_tready,
	// level [15:0], now_seconds [47:16]
	input  logic [IN_DATA_W-1:0]  s_tdata,
	output logic                  m_tvalid,
	input  logic                  m_tready,
	// sag_active [0], interrupt_active [1], sag_done [2], interrupt_done [3],
	// sag_ticks [35:4], sag_begin [67:36], interrupt_ticks [99:68],
	// interrupt_begin [131:100], zero fill [135:132]
	output logic [OUT_DATA_W-1:0] m_tdata,
	input  logic                  cfg_we,
	input  logic [0:0]            cfg_index,
	input  logic [CFG_W-1:0]      cfg_data
);

	logic [LEVEL_W-1:0] sag_thr_q;
	logic [LEVEL_W-1:0] int_thr_q;

	logic               valid_s1;
	logic [LEVEL_W-1:0] level_s1;
	logic [TIME_W-1:0]  now_s1;

	logic               valid_s2;
	det_res_t           sag_s2;
	det_res_t           int_s2;

	logic               advance;
	det_res_t           sag_res;
	det_res_t           int_res;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sag_thr_q <= SAG_THR_RESET;
			int_thr_q <= INT_THR_RESET;
		end else if (cfg_we) begin
			case (cfg_reg_t'(cfg_index))
				REG_SAG_THR: sag_thr_q <= cfg_data;
				REG_INT_THR: int_thr_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// The input register moves on whenever the result register is free or being drained.
	assign advance  = valid_s1 && (!valid_s2 || m_tready);
	assign s_tready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			level_s1 <= s_tdata[LEVEL_W-1:0];
			now_s1   <= s_tdata[LEVEL_W +: TIME_W];
		end
	end

	vsid_det u_sag (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (advance),
		.cond   (level_s1 < sag_thr_q),
		.now    (now_s1),
		.res    (sag_res)
	);

	vsid_det u_int (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (advance),
		.cond   (level_s1 <= int_thr_q),
		.now    (now_s1),
		.res    (int_res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (!valid_s2 || m_tready) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			sag_s2 <= sag_res;
			int_s2 <= int_res;
		end
	end

	assign m_tvalid = valid_s2;
	assign m_tdata  = {4'b0000, int_s2.begin_time, int_s2.ticks,
		sag_s2.begin_time, sag_s2.ticks,
		int_s2.done, sag_s2.done, int_s2.active, sag_s2.active};

	// An event that ends in a beat is no longer active in that beat.
	a_sag_done_inactive: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && sag_s2.done |-> !sag_s2.active)
		else $error("sag reported done while still active");

	a_int_done_inactive: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && int_s2.done |-> !int_s2.active)
		else $error("interruption reported done while still active");

	a_sag_quiet_fields: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !sag_s2.done |-> sag_s2.ticks == '0 && sag_s2.begin_time == '0)
		else $error("sag duration fields set without an ended sag");

	// With both registers full and the output stalled, no new beat may enter.
	a_full_stall: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && valid_s2 && !m_tready |-> !s_tready)
		else $error("input accepted while pipeline is full and stalled");

endmodule
